// File: design/sexpr_lex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lex_pkg
// Types, codes and character-class helpers for the s-expression lexer.
// ----------------------------------------------------------------------------
package sexpr_lex_pkg;

  localparam int unsigned NUM_PUNCT = 19;

  localparam logic [4:0] KIND_OPEN   = 5'd0;
  localparam logic [4:0] KIND_CLOSE  = 5'd1;
  localparam logic [4:0] KIND_STRING = 5'd19;
  localparam logic [4:0] KIND_ATOM   = 5'd20;
  localparam logic [4:0] KIND_NUMBER = 5'd21;

  localparam logic [7:0] QUOTE_CODE = 8'd39;
  localparam logic [7:0] DOT_CODE   = 8'd46;

  // ( ) [ ] { } ! @ # $ % ^ & * - + ? : ;  -> kinds 0..18
  localparam logic [7:0] PUNCT_CODES [NUM_PUNCT] = '{
    8'd40, 8'd41, 8'd91, 8'd93, 8'd123, 8'd125, 8'd33, 8'd64, 8'd35, 8'd36,
    8'd37, 8'd94, 8'd38, 8'd42, 8'd45, 8'd43, 8'd63, 8'd58, 8'd59
  };

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_STR  = 4'b0010,
    MODE_ATOM = 4'b0100,
    MODE_NUM  = 4'b1000
  } lex_mode_e;

  // Packed so the last field (token_kind) lands in the low bits of tdata.
  typedef struct packed {
    logic       err;
    logic       token_done;
    logic [7:0] text_char;
    logic       has_char;
    logic [4:0] token_kind;
  } res_t;

  typedef struct packed {
    logic [1:0] cnt;   // results produced by this beat, 0..2
    res_t       r1;
    res_t       r0;
  } step_t;

  typedef struct packed {
    logic last;
    res_t res;
  } obuf_ent_t;

  typedef struct packed {
    logic      vld;
    lex_mode_e mode;
    res_t      res;
  } idle_lex_t;

  function automatic res_t mk_res(logic [4:0] kind, logic has, logic [7:0] ch,
                                  logic done, logic err);
    res_t r;
    r.token_kind = kind;
    r.has_char   = has;
    r.text_char  = ch;
    r.token_done = done;
    r.err        = err;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'd48 && c <= 8'd57);
  endfunction

endpackage

// File: design/sexpr_lex_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lex_core
// Lexer state and the per-character decode producing up to two results.
// ----------------------------------------------------------------------------
module sexpr_lex_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 func_i,
  input  logic [7:0]           char_i,
  output sexpr_lex_pkg::step_t step_o
);
  import sexpr_lex_pkg::*;

  lex_mode_e mode_q, mode_d;
  logic      started_q, started_d;

  // Fresh lex of one byte outside any token.
  function automatic idle_lex_t lex_idle(logic [7:0] c);
    idle_lex_t o;
    logic      hit;
    logic [4:0] idx;
    hit = 1'b0;
    idx = '0;
    for (int i = 0; i < NUM_PUNCT; i++) begin
      if (PUNCT_CODES[i] == c) begin
        hit = 1'b1;
        idx = 5'(i);
      end
    end
    o.vld  = 1'b1;
    o.mode = MODE_IDLE;
    o.res  = '0;
    priority if (is_space(c)) begin
      o.vld = 1'b0;
    end else if (hit) begin
      o.res = mk_res(idx, 1'b0, 8'd0, 1'b1, 1'b0);
    end else if (c == QUOTE_CODE) begin
      o.vld  = 1'b0;
      o.mode = MODE_STR;
    end else if (is_alpha(c)) begin
      o.mode = MODE_ATOM;
      o.res  = mk_res(KIND_ATOM, 1'b1, c, 1'b0, 1'b0);
    end else if (is_digit(c) || c == DOT_CODE) begin
      o.mode = MODE_NUM;
      o.res  = mk_res(KIND_NUMBER, 1'b1, c, 1'b0, 1'b0);
    end else begin
      o.res = mk_res(KIND_OPEN, 1'b0, c, 1'b1, 1'b1);
    end
    return o;
  endfunction

  lex_mode_e mode_eff;
  idle_lex_t il;
  logic      open_v, a_v, b_v;
  res_t      a_res, b_res, open_res;

  always_comb begin
    open_v   = !started_q;
    mode_eff = started_q ? mode_q : MODE_IDLE;
    open_res = mk_res(KIND_OPEN, 1'b0, 8'd0, 1'b1, 1'b0);
    il       = lex_idle(char_i);
    a_v      = 1'b0;
    b_v      = 1'b0;
    a_res    = '0;
    b_res    = '0;
    mode_d   = mode_eff;
    started_d = 1'b1;

    if (func_i) begin
      // end of text: close pending token, then the closing paren
      b_v       = 1'b1;
      b_res     = mk_res(KIND_CLOSE, 1'b0, 8'd0, 1'b1, 1'b0);
      mode_d    = MODE_IDLE;
      started_d = 1'b0;
      unique case (mode_eff)
        MODE_STR: begin
          a_v   = 1'b1;
          a_res = mk_res(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b1);
        end
        MODE_ATOM: begin
          a_v   = 1'b1;
          a_res = mk_res(KIND_ATOM, 1'b0, 8'd0, 1'b1, 1'b0);
        end
        MODE_NUM: begin
          a_v   = 1'b1;
          a_res = mk_res(KIND_NUMBER, 1'b0, 8'd0, 1'b1, 1'b0);
        end
        default: ;
      endcase
    end else begin
      unique case (mode_eff)
        MODE_STR: begin
          a_v = 1'b1;
          if (char_i == QUOTE_CODE) begin
            a_res  = mk_res(KIND_STRING, 1'b0, 8'd0, 1'b1, 1'b0);
            mode_d = MODE_IDLE;
          end else begin
            a_res = mk_res(KIND_STRING, 1'b1, char_i, 1'b0, 1'b0);
          end
        end
        MODE_ATOM: begin
          a_v = 1'b1;
          if (is_alpha(char_i) || is_digit(char_i)) begin
            a_res = mk_res(KIND_ATOM, 1'b1, char_i, 1'b0, 1'b0);
          end else begin
            a_res  = mk_res(KIND_ATOM, 1'b0, 8'd0, 1'b1, 1'b0);
            b_v    = il.vld;
            b_res  = il.res;
            mode_d = il.mode;
          end
        end
        MODE_NUM: begin
          a_v = 1'b1;
          if (is_digit(char_i) || char_i == DOT_CODE) begin
            a_res = mk_res(KIND_NUMBER, 1'b1, char_i, 1'b0, 1'b0);
          end else begin
            a_res  = mk_res(KIND_NUMBER, 1'b0, 8'd0, 1'b1, 1'b0);
            b_v    = il.vld;
            b_res  = il.res;
            mode_d = il.mode;
          end
        end
        default: begin
          a_v    = il.vld;
          a_res  = il.res;
          mode_d = il.mode;
        end
      endcase
    end

    // open, a, b in order; never all three at once
    step_o.cnt = 2'(open_v) + 2'(a_v) + 2'(b_v);
    step_o.r0  = open_v ? open_res : (a_v ? a_res : b_res);
    step_o.r1  = open_v ? (a_v ? a_res : b_res) : b_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      started_q <= 1'b0;
    end else if (step_i) begin
      mode_q    <= mode_d;
      started_q <= started_d;
    end
  end

endmodule

// File: design/sexpr_lex_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lex_obuf
// Four-entry result queue: takes up to two results per beat, sends one.
// ----------------------------------------------------------------------------
module sexpr_lex_obuf (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sexpr_lex_pkg::step_t step_i,
  output logic                 room_o,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,
  output logic                 m_axis_tlast
);
  import sexpr_lex_pkg::*;

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);

  obuf_ent_t           ent_q [Depth];
  logic [PtrW-1:0]     wp_q, rp_q;
  logic [PtrW:0]       cnt_q, cnt_d;
  logic [PtrW+1:0]     fill;
  logic                pop;
  logic [PtrW-1:0]     wp1;

  assign fill   = {1'b0, cnt_q} + (PtrW+2)'(step_i.cnt);
  assign room_o = (fill <= (PtrW+2)'(Depth));
  assign pop    = m_axis_tvalid && m_axis_tready;
  assign wp1    = wp_q + 1'b1;

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = ent_q[rp_q].res;
  assign m_axis_tlast  = ent_q[rp_q].last;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i) cnt_d = cnt_d + (PtrW+1)'(step_i.cnt);
    if (pop)    cnt_d = cnt_d - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= wp_q + PtrW'(step_i.cnt);
      if (pop)    rp_q <= rp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && step_i.cnt != 2'd0) begin
      ent_q[wp_q].res  <= step_i.r0;
      ent_q[wp_q].last <= (step_i.cnt == 2'd1);
    end
    if (push_i && step_i.cnt == 2'd2) begin
      ent_q[wp1].res  <= step_i.r1;
      ent_q[wp1].last <= 1'b1;
    end
  end

endmodule

// File: design/sexpr_char_lexer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_char_lexer_top
// Streaming s-expression lexer: one source byte per beat in, token beats out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_axis_tdata carries the source byte, s_axis_tuser marks the
//   end of text (1) versus an ordinary character (0; tdata ignored at end).
//   Master side: one beat per token result; tlast flags the final result
//   caused by a given input beat. Inputs that give no result (whitespace,
//   an opening quote) produce no output beat.
//   First byte of a text is preceded by an implicit '(' token; end of text
//   flushes any pending atom/number/string and then emits an implicit ')'.
// Timing:
//   Input beat is registered, decoded combinationally and written to a 4-entry
//   result queue; the first result is offered from the queue register once
//   the decode has written it there.
//   Sustained rate is one input beat per cycle while each yields at most one
//   result and m_axis_tready stays high; the output port sends one result per
//   cycle, so the queue absorbs the extra result of a beat giving two.
//   s_axis_tready depends only on registered state (queue fill, input reg).
// Reset: queue emptied, lexer idle with no opening token sent yet.
// Stall: when m_axis_tready is low the queue fills; once it lacks room for
//   the decoded beat's results, the input register holds and tready drops.
// ----------------------------------------------------------------------------
module sexpr_char_lexer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic        s_axis_tuser,   // [0] func (1 = end of text)
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [4:0] token_kind, [5] has_char,
                                      // [13:6] text_char, [14] token_done,
                                      // [15] error
  output logic        m_axis_tlast    // last result of this input beat
);
  import sexpr_lex_pkg::*;

  logic       in_vld_q;
  logic       in_func_q;
  logic [7:0] in_char_q;
  logic       step;
  logic       room;
  step_t      step_res;

  // decode fires when the queue can take every result of this beat
  assign step          = in_vld_q && room;
  assign s_axis_tready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload only, no reset needed
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_func_q <= s_axis_tuser;
      in_char_q <= s_axis_tdata;
    end
  end

  sexpr_lex_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .func_i (in_func_q),
    .char_i (in_char_q),
    .step_o (step_res)
  );

  sexpr_lex_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (step),
    .step_i        (step_res),
    .room_o        (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: design/sexpr_lex_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sexpr_lex_chk
// Port-level checks on the lexer's result stream.
// ----------------------------------------------------------------------------
module sexpr_lex_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import sexpr_lex_pkg::*;

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  // lexeme characters only on string/atom/number, never with done or error
  a_char_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[5] |->
      !m_axis_tdata[14] && !m_axis_tdata[15] &&
      (m_axis_tdata[4:0] == KIND_STRING || m_axis_tdata[4:0] == KIND_ATOM ||
       m_axis_tdata[4:0] == KIND_NUMBER))
    else $error("lexeme char on wrong token");

  // errors are done results of kind 0 or an unterminated string
  a_err_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15] |->
      m_axis_tdata[14] && !m_axis_tdata[5] &&
      (m_axis_tdata[4:0] == KIND_OPEN || m_axis_tdata[4:0] == KIND_STRING))
    else $error("malformed error result");

  // closing token is always the last result of its input beat
  a_close_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[4:0] == KIND_CLOSE && !m_axis_tdata[15] |->
      m_axis_tlast && m_axis_tdata[14])
    else $error("closing token not last");

  // no result beat right out of reset before any input
  a_idle_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result beat after reset");

endmodule

bind sexpr_char_lexer_top sexpr_lex_chk u_sexpr_lex_chk (.*);
